[hw/rtl/stcl_pkg.sv]
// ----------------------------------------------------------------------------
// stcl_pkg
// shared codes and controller/datapath interface types for the stsc lookup
// ----------------------------------------------------------------------------
package stcl_pkg;

	localparam logic [1:0] ACT_CLEAR  = 2'd0;
	localparam logic [1:0] ACT_LOAD   = 2'd1;
	localparam logic [1:0] ACT_LOOKUP = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_EMPTY   = 2'd2;
	localparam logic [1:0] ST_FULL    = 2'd3;

	localparam int DIV_STEPS = 32;

	// commands from controller to datapath
	typedef struct packed {
		logic       cap_in;
		logic       clr;
		logic       ld_cnt;
		logic       ld_sum;
		logic       ld_wr;
		logic       g_cached;
		logic       g_zero;
		logic       g_inc;
		logic       rd;
		logic       cap_ent;
		logic       div_start;
		logic       div_step;
		logic       set_cache;
		logic       out_load;
		logic       out_ok;
		logic [1:0] out_status;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic [1:0] action;
		logic       in_sample_zero;
		logic       empty;
		logic       full;
		logic       ram_fs_gt;
		logic       prod_zero;
		logic       fs_gt;
		logic       walk_past;
		logic       g_last;
		logic       spc_zero;
		logic       div_done;
		logic       out_free;
	} sts_t;

endpackage

[hw/rtl/sample_to_chunk_table_lookup_top.sv]
// ----------------------------------------------------------------------------
// sample_to_chunk_table_lookup_top
// sample-to-chunk table engine: clear, load entries, locate a sample's chunk
// ----------------------------------------------------------------------------
// usage:
//   requests enter on s_*: s_tuser holds the action (clear, load, lookup),
//   s_tdata the entry fields and the sample number. every request gives
//   exactly one result on m_*: m_tuser is the status, m_tdata the chunk
//   number, skip within the chunk and description index (zero unless ok).
//   one request is in flight at a time; s_tready is high while idle.
//   a lookup reads each table group through the registered table read,
//   walking on past groups that end at or before the sample and restarting
//   at group 0 when the cached group starts after the sample, then runs
//   the 32-step restoring divider.
//   a finished result sits in the output register; the next request is
//   taken while it waits, and only the step that writes the following
//   result stalls until m_tready frees the register.
//   reset clears the entry count, cached group and running sample sum;
//   the table memories are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module sample_to_chunk_table_lookup_top #(
	parameter int TABLE_DEPTH = 256
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,   // first_chunk, samples_per_chunk, description_index, sample_number
	input  logic [1:0]   s_tuser,   // action
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [95:0]  m_tdata,   // chunk_number, skip_in_chunk, description_index_out
	output logic [1:0]   m_tuser    // status
);

	stcl_pkg::cmd_t cmd;
	stcl_pkg::sts_t sts;

	// sequencer
	stcl_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_ready(s_tready),
		.sts(sts), .cmd(cmd)
	);

	// table, arithmetic and result register
	stcl_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
		.clk(clk), .arst_n(arst_n),
		.cmd(cmd), .sts(sts),
		.in_action(s_tuser), .in_data(s_tdata),
		.out_ready(m_tready), .out_valid(m_tvalid),
		.out_status(m_tuser), .out_data(m_tdata)
	);

endmodule

[hw/rtl/stcl_ram.sv]
// ----------------------------------------------------------------------------
// stcl_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module stcl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                                  clk,
	input  logic                                  wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                      wr_data,
	input  logic                                  rd_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                      rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

[hw/rtl/stcl_dp.sv]
// ----------------------------------------------------------------------------
// stcl_dp
// table storage, load arithmetic, walk compare, serial divider, result register
// ----------------------------------------------------------------------------
module stcl_dp #(
	parameter int TABLE_DEPTH = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  stcl_pkg::cmd_t     cmd,
	output stcl_pkg::sts_t     sts,
	input  logic [1:0]         in_action,
	input  logic [127:0]       in_data,
	input  logic               out_ready,
	output logic               out_valid,
	output logic [1:0]         out_status,
	output logic [95:0]        out_data
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	logic [31:0]   fc_q, spc_q, desc_q, sample_q;
	logic [CW-1:0] used_q, g_q;
	logic [AW-1:0] cached_q;
	logic [31:0]   running_q, last_fc_q, last_spc_q, prod_q;
	logic [31:0]   fc_e_q, fs_e_q, spc_e_q, desc_e_q;
	logic [31:0]   rem_q;
	logic [31:0]   quo_q;
	logic [5:0]    cnt_q;
	logic          out_valid_q;
	logic [1:0]    out_status_q;
	logic [95:0]   out_data_q;

	logic [127:0]  a_wdata, a_rdata;
	logic [31:0]   b_wdata, b_rdata;
	logic          b_wen;
	logic [AW-1:0] b_waddr, used_addr, prev_addr;
	logic [31:0]   ld_cnt;
	logic [32:0]   rem_sh;
	logic          out_free;

	assign used_addr = used_q[AW-1:0];
	assign prev_addr = AW'(used_q - CW'(1));
	assign ld_cnt    = fc_q - last_fc_q;
	assign a_wdata   = {desc_q, spc_q, running_q, fc_q};
	assign b_wen     = (cmd.ld_cnt && (used_q != '0)) || cmd.ld_wr;
	assign b_waddr   = cmd.ld_wr ? used_addr : prev_addr;
	assign b_wdata   = cmd.ld_wr ? 32'd0 : ld_cnt;

	// a: first chunk, first sample, samples per chunk, description
	stcl_ram #(.WIDTH(128), .DEPTH(TABLE_DEPTH)) u_ram_a (
		.clk(clk), .wr_en(cmd.ld_wr), .wr_addr(used_addr), .wr_data(a_wdata),
		.rd_en(cmd.rd), .rd_addr(g_q[AW-1:0]), .rd_data(a_rdata)
	);

	// b: chunk count, closed by the following load
	stcl_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_ram_b (
		.clk(clk), .wr_en(b_wen), .wr_addr(b_waddr), .wr_data(b_wdata),
		.rd_en(cmd.rd), .rd_addr(g_q[AW-1:0]), .rd_data(b_rdata)
	);

	assign rem_sh   = {rem_q, quo_q[31]};
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			cached_q    <= '0;
			running_q   <= 32'd1;
			g_q         <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr) begin
				used_q    <= '0;
				cached_q  <= '0;
				running_q <= 32'd1;
			end
			if (cmd.ld_sum) begin
				running_q <= running_q + prod_q;
			end
			if (cmd.ld_wr) begin
				used_q <= used_q + CW'(1);
			end
			if (cmd.g_cached) begin
				g_q <= CW'(cached_q);
			end else if (cmd.g_zero) begin
				g_q <= '0;
			end else if (cmd.g_inc) begin
				g_q <= g_q + CW'(1);
			end
			if (cmd.set_cache) begin
				cached_q <= g_q[AW-1:0];
			end
			if (cmd.div_start) begin
				cnt_q <= '0;
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q + 6'd1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_in) begin
			fc_q     <= in_data[31:0];
			spc_q    <= in_data[63:32];
			desc_q   <= in_data[95:64];
			sample_q <= in_data[127:96];
		end
		if (cmd.ld_cnt) begin
			prod_q <= (used_q != '0) ? ld_cnt * last_spc_q : 32'd0;
		end
		if (cmd.ld_wr) begin
			last_fc_q  <= fc_q;
			last_spc_q <= spc_q;
		end
		if (cmd.cap_ent) begin
			fc_e_q   <= a_rdata[31:0];
			fs_e_q   <= a_rdata[63:32];
			spc_e_q  <= a_rdata[95:64];
			desc_e_q <= a_rdata[127:96];
			prod_q   <= b_rdata * a_rdata[95:64];
		end
		if (cmd.div_start) begin
			rem_q <= '0;
			quo_q <= sample_q - fs_e_q;
		end else if (cmd.div_step) begin
			// partial remainder stays below the divisor, so 32 bits hold it
			if (rem_sh >= {1'b0, spc_e_q}) begin
				rem_q <= rem_sh[31:0] - spc_e_q;
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= rem_sh[31:0];
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
		if (cmd.out_load) begin
			out_status_q <= cmd.out_status;
			out_data_q   <= cmd.out_ok ? {desc_e_q, rem_q, fc_e_q + quo_q} : 96'd0;
		end
	end

	assign sts.action         = in_action;
	assign sts.in_sample_zero = (in_data[127:96] == 32'd0);
	assign sts.empty          = (used_q == '0);
	assign sts.full           = (used_q == CW'(TABLE_DEPTH));
	assign sts.ram_fs_gt      = (a_rdata[63:32] > sample_q);
	assign sts.prod_zero      = (prod_q == 32'd0);
	assign sts.fs_gt          = (fs_e_q > sample_q);
	assign sts.walk_past      = ((fs_e_q + prod_q) <= sample_q);
	assign sts.g_last         = ({1'b0, g_q} + (CW+1)'(1) >= {1'b0, used_q});
	assign sts.spc_zero       = (spc_e_q == 32'd0);
	assign sts.div_done       = (cnt_q == 6'(stcl_pkg::DIV_STEPS));
	assign sts.out_free       = out_free;

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_data   = out_data_q;

endmodule

[hw/rtl/stcl_ctrl.sv]
// ----------------------------------------------------------------------------
// stcl_ctrl
// sequencer for clear, load and lookup requests
// ----------------------------------------------------------------------------
module stcl_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  stcl_pkg::sts_t sts,
	output stcl_pkg::cmd_t cmd
);

	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_LD_CNT = 9'b000000010,
		S_LD_SUM = 9'b000000100,
		S_LD_WR  = 9'b000001000,
		S_LK_RD  = 9'b000010000,
		S_LK_CAP = 9'b000100000,
		S_LK_DEC = 9'b001000000,
		S_DIV    = 9'b010000000,
		S_FIN    = 9'b100000000
	} state_t;

	state_t     state_q, state_d;
	logic       first_q, first_d;
	logic [1:0] st_q, st_d;
	logic       ok_q, ok_d;
	logic       accept;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		first_d = first_q;
		st_d    = st_q;
		ok_d    = ok_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.cap_in = 1'b1;
					st_d       = stcl_pkg::ST_OK;
					ok_d       = 1'b0;
					state_d    = S_FIN;
					unique case (sts.action)
						stcl_pkg::ACT_CLEAR: cmd.clr = 1'b1;
						stcl_pkg::ACT_LOAD: begin
							if (sts.full) st_d = stcl_pkg::ST_FULL;
							else state_d = S_LD_CNT;
						end
						stcl_pkg::ACT_LOOKUP: begin
							if (sts.in_sample_zero) begin
								st_d = stcl_pkg::ST_INVALID;
							end else if (sts.empty) begin
								st_d = stcl_pkg::ST_EMPTY;
							end else begin
								cmd.g_cached = 1'b1;
								first_d      = 1'b1;
								state_d      = S_LK_RD;
							end
						end
						default: ;
					endcase
				end
			end
			S_LD_CNT: begin
				cmd.ld_cnt = 1'b1;
				state_d    = S_LD_SUM;
			end
			S_LD_SUM: begin
				cmd.ld_sum = 1'b1;
				state_d    = S_LD_WR;
			end
			S_LD_WR: begin
				cmd.ld_wr = 1'b1;
				state_d   = S_FIN;
			end
			S_LK_RD: begin
				cmd.rd  = 1'b1;
				state_d = S_LK_CAP;
			end
			S_LK_CAP: begin
				// cached group starts after the sample: restart at group 0
				if (first_q && sts.ram_fs_gt) begin
					cmd.g_zero = 1'b1;
					state_d    = S_LK_RD;
				end else begin
					cmd.cap_ent = 1'b1;
					state_d     = S_LK_DEC;
				end
				first_d = 1'b0;
			end
			S_LK_DEC: begin
				if (sts.prod_zero && sts.fs_gt) begin
					st_d    = stcl_pkg::ST_INVALID;
					state_d = S_FIN;
				end else if (!sts.prod_zero && sts.walk_past) begin
					if (sts.g_last) begin
						st_d    = stcl_pkg::ST_INVALID;
						state_d = S_FIN;
					end else begin
						cmd.g_inc = 1'b1;
						state_d   = S_LK_RD;
					end
				end else if (sts.spc_zero) begin
					st_d    = stcl_pkg::ST_INVALID;
					state_d = S_FIN;
				end else begin
					cmd.div_start = 1'b1;
					cmd.set_cache = 1'b1;
					state_d       = S_DIV;
				end
			end
			S_DIV: begin
				if (sts.div_done) begin
					ok_d    = 1'b1;
					state_d = S_FIN;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.out_load   = 1'b1;
					cmd.out_ok     = ok_q;
					cmd.out_status = st_q;
					state_d        = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			first_q <= 1'b0;
			st_q    <= stcl_pkg::ST_OK;
			ok_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			first_q <= first_d;
			st_q    <= st_d;
			ok_q    <= ok_d;
		end
	end

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free) else $error("result overwritten");
	a_div_spc: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !sts.spc_zero) else $error("divide by zero started");
	a_ld_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ld_wr |-> !sts.full) else $error("write into full table");
	a_ok_status: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_load && cmd.out_ok) |-> (cmd.out_status == stcl_pkg::ST_OK))
		else $error("ok lookup with error status");

endmodule

[tb/sample_to_chunk_table_lookup_top_test.sv]
// ----------------------------------------------------------------------------
// sample_to_chunk_table_lookup_top_test
// drives clear, load and lookup requests into the stsc engine, predicts each
// result from a local table model and checks every result field in order
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

// expected result of one request
typedef struct packed {
	logic [1:0]  status;
	logic [31:0] chunk;
	logic [31:0] skip;
	logic [31:0] desc;
} stsc_result_t;

class stsc_scoreboard;
	// local copy of the table state
	logic [31:0] tbl_first_chunk[256];
	logic [31:0] tbl_first_sample[256];
	logic [31:0] tbl_count[256];
	logic [31:0] tbl_spc[256];
	logic [31:0] tbl_desc[256];
	int unsigned used;
	int unsigned cache_grp;
	logic [31:0] sample_sum;
	stsc_result_t pending[$];
	int errors;

	function new();
		used = 0;
		cache_grp = 0;
		sample_sum = 1;
		errors = 0;
	endfunction

	function stsc_result_t locate(logic [31:0] sample);
		stsc_result_t r;
		int unsigned g;
		logic [31:0] fs, spc, span, off;
		r = '0;
		if (sample == 0) begin
			r.status = stcl_pkg::ST_INVALID;
			return r;
		end
		if (used == 0) begin
			r.status = stcl_pkg::ST_EMPTY;
			return r;
		end
		g = (cache_grp < used && tbl_first_sample[cache_grp] <= sample) ? cache_grp : 0;
		for (; g < used; g++) begin
			fs = tbl_first_sample[g];
			spc = tbl_spc[g];
			span = tbl_count[g] * spc;
			if (span == 0) begin
				if (fs > sample) begin
					r.status = stcl_pkg::ST_INVALID;
					return r;
				end
			end else if (fs + span <= sample) begin
				continue;
			end
			if (spc == 0) begin
				r.status = stcl_pkg::ST_INVALID;
				return r;
			end
			off = (sample - fs) / spc;
			cache_grp = g;
			r.status = stcl_pkg::ST_OK;
			r.chunk = tbl_first_chunk[g] + off;
			r.skip = sample - (fs + spc * off);
			r.desc = tbl_desc[g];
			return r;
		end
		r.status = stcl_pkg::ST_INVALID;
		return r;
	endfunction

	// note an accepted request and queue its expected result
	function void note_request(logic [1:0] act, logic [31:0] fc, logic [31:0] spc,
	                           logic [31:0] desc, logic [31:0] sample);
		stsc_result_t r;
		logic [31:0] cnt;
		r = '0;
		case (act)
			stcl_pkg::ACT_CLEAR: begin
				used = 0;
				cache_grp = 0;
				sample_sum = 1;
			end
			stcl_pkg::ACT_LOAD: begin
				if (used >= 256) begin
					r.status = stcl_pkg::ST_FULL;
				end else begin
					if (used > 0) begin
						cnt = fc - tbl_first_chunk[used-1];
						tbl_count[used-1] = cnt;
						sample_sum += cnt * tbl_spc[used-1];
					end
					tbl_first_chunk[used] = fc;
					tbl_first_sample[used] = sample_sum;
					tbl_count[used] = 0;
					tbl_spc[used] = spc;
					tbl_desc[used] = desc;
					used++;
				end
			end
			stcl_pkg::ACT_LOOKUP: r = locate(sample);
			default: ;
		endcase
		pending.push_back(r);
	endfunction

	function void check_result(logic [1:0] st, logic [95:0] data);
		stsc_result_t e;
		if (pending.size() == 0) begin
			$error("unexpected result status=%0d data=%h", st, data);
			errors++;
			return;
		end
		e = pending.pop_front();
		if (st !== e.status) begin
			$error("status expected %0d actual %0d", e.status, st);
			errors++;
		end
		if (data[31:0] !== e.chunk) begin
			$error("chunk_number expected %0d actual %0d", e.chunk, data[31:0]);
			errors++;
		end
		if (data[63:32] !== e.skip) begin
			$error("skip_in_chunk expected %0d actual %0d", e.skip, data[63:32]);
			errors++;
		end
		if (data[95:64] !== e.desc) begin
			$error("description_index_out expected %0d actual %0d", e.desc, data[95:64]);
			errors++;
		end
	endfunction
endclass

module sample_to_chunk_table_lookup_top_test;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [127:0] s_tdata;   // first_chunk, samples_per_chunk, description_index, sample_number
	logic [1:0]   s_tuser;   // action
	logic         m_tvalid;
	logic         m_tready;
	logic [95:0]  m_tdata;   // chunk_number, skip_in_chunk, description_index_out
	logic [1:0]   m_tuser;   // status

	stsc_scoreboard board;
	int send_idle_pct;   // percent of cycles the sender holds off
	int recv_idle_pct;   // percent of cycles the receiver stalls

	sample_to_chunk_table_lookup_top i_dut (.*);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// global watchdog, far beyond the slowest legal run
	initial begin
		#40ms;
		$display("sample_to_chunk_table_lookup_top test failed");
		$finish;
	end

	// receiver: random stalls, check every accepted result
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready)
				board.check_result(m_tuser, m_tdata);
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// send one request; tvalid stays high across back-to-back requests
	task automatic send_request(logic [1:0] act, logic [31:0] fc, logic [31:0] spc,
	                            logic [31:0] desc, logic [31:0] sample);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= {sample, desc, spc, fc};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		board.note_request(act, fc, spc, desc, sample);
	endtask

	task automatic load_entry(logic [31:0] fc, logic [31:0] spc, logic [31:0] desc);
		send_request(stcl_pkg::ACT_LOAD, fc, spc, desc, $urandom);
	endtask

	task automatic look_up(logic [31:0] sample);
		send_request(stcl_pkg::ACT_LOOKUP, $urandom, $urandom, $urandom, sample);
	endtask

	// a well-formed table of a few groups, then lookups mostly inside it
	task automatic random_table_session(int n_look);
		int groups;
		logic [31:0] fc;
		logic [31:0] top_sample;
		groups = $urandom_range(6, 1);
		fc = $urandom_range(3, 1);
		top_sample = 1;
		send_request(stcl_pkg::ACT_CLEAR, $urandom, $urandom, $urandom, $urandom);
		for (int g = 0; g < groups; g++) begin
			logic [31:0] spc, step;
			spc = ($urandom_range(19) == 0) ? 0 :
			      ($urandom_range(9) == 0) ? $urandom : $urandom_range(12, 1);
			step = $urandom_range(5, 1);
			load_entry(fc, spc, $urandom_range(3) == 0 ? $urandom : $urandom_range(4, 1));
			top_sample += step * spc;
			fc += step;
		end
		for (int k = 0; k < n_look; k++) begin
			case ($urandom_range(9))
				0: look_up($urandom);
				1: send_request(2'($urandom_range(3)), $urandom, $urandom, $urandom,
				                $urandom);
				default: look_up($urandom_range(top_sample + 20, 1));
			endcase
		end
	endtask

	task automatic run_phase(int s_idle, int r_idle, int sessions);
		send_idle_pct = s_idle;
		recv_idle_pct = r_idle;
		for (int s = 0; s < sessions; s++)
			random_table_session($urandom_range(12, 2));
	endtask

	initial begin
		int wait_cycles;
		board = new();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = '0;
		s_tuser = stcl_pkg::ACT_CLEAR;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, sample zero, extremes, unused action
		look_up(5);
		look_up(0);
		send_request(2'd3, '1, '1, '1, '1);
		load_entry(32'd1, 32'd3, 32'd1);
		load_entry(32'd4, 32'd0, 32'd2);    // zero samples per chunk
		load_entry(32'd6, '1, '1);
		look_up(32'd1);
		look_up(32'd9);
		look_up(32'd10);                    // lands in zero-spc group
		look_up('1);
		look_up(32'd2);                     // cached group holds the sample
		look_up(0);
		send_request(stcl_pkg::ACT_CLEAR, '0, '0, '0, '0);
		load_entry(32'd10, 32'd2, 32'd7);
		look_up(32'd3);                     // last group, chunk count still open
		send_request(stcl_pkg::ACT_CLEAR, '0, '0, '0, '0);
		load_entry('1, '1, '0);
		load_entry(32'd0, '1, '1);          // wrapped chunk difference
		look_up(32'h8000_0000);
		look_up(32'd1);
		// fill the table past its depth
		send_request(stcl_pkg::ACT_CLEAR, '0, '0, '0, '0);
		for (int i = 0; i < 258; i++)
			load_entry(i + 1, $urandom_range(4, 1), i);
		look_up(32'd700);
		look_up(32'd3);

		// random: receiver idles, then sender idles, then neither
		run_phase(6, 77, 35);
		run_phase(77, 6, 35);
		run_phase(0, 0, 35);

		s_tvalid <= 1'b0;
		wait_cycles = 0;
		while (board.pending.size() != 0 && wait_cycles < 100000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (100) @(posedge clk);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("sample_to_chunk_table_lookup_top test passed");
		else
			$display("sample_to_chunk_table_lookup_top test failed");
		$finish;
	end

endmodule
